FILE: design/double_to_int_convert_top_defines.svh
// assertion macros for the double to integer converter
`ifndef DOUBLE_TO_INT_CONVERT_TOP_DEFINES_SVH
`define DOUBLE_TO_INT_CONVERT_TOP_DEFINES_SVH

// property that must hold on every clock edge outside reset
`define D2I_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define D2I_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/d2i_pkg.sv
// package for the double to integer converter: types, constants and the conversion function
package d2i_pkg;

  typedef enum logic [1:0] {
    RM_NEAREST_EVEN = 2'd0,
    RM_DOWN         = 2'd1,
    RM_UP           = 2'd2,
    RM_ZERO         = 2'd3
  } rmode_e;

  localparam logic [63:0] Ind64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Ind32 = 64'h0000_0000_8000_0000;
  localparam logic [63:0] Max64 = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] Max32 = 64'h0000_0000_7fff_ffff;

  typedef struct packed {
    logic [63:0] source_bits;
    logic        operation;
    logic        result_is_64bit;
  } d2i_in_t;

  typedef struct packed {
    logic [63:0] result_bits;
  } d2i_out_t;

  function automatic logic [63:0] convert(input logic [63:0] bits, input rmode_e mode,
                                          input logic wide);
    logic        neg;
    logic [10:0] expo;
    logic [52:0] m;
    logic [11:0] sh_pos;
    logic [11:0] rs;
    logic [63:0] ip;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] mask;
    logic        inc;
    logic [63:0] mag;
    logic [63:0] lim;
    logic [63:0] indef;
    logic [63:0] res;
    neg   = bits[63];
    expo  = bits[62:52];
    m     = {(expo != 11'd0), bits[51:0]};
    indef = wide ? Ind64 : Ind32;
    inc   = 1'b0;
    rem   = '0;
    half  = '0;
    ip    = '0;
    // biased exponent used for the shift; subnormals use exponent one
    sh_pos = (expo == 11'd0) ? 12'd1 : {1'b0, expo};
    if (expo == 11'h7ff || sh_pos >= 12'd1086) begin
      res = indef;
    end else begin
      if (sh_pos >= 12'd1075) begin
        ip = {11'd0, m} << (sh_pos - 12'd1075);
      end else begin
        rs = 12'd1075 - sh_pos;
        if (rs >= 12'd60) begin
          ip   = '0;
          rem  = {63'd0, (m != 53'd0)};
          half = 64'd1 << 58;
        end else begin
          mask = (64'd1 << rs[5:0]) - 64'd1;
          ip   = {11'd0, m} >> rs[5:0];
          rem  = {11'd0, m} & mask;
          half = 64'd1 << (rs[5:0] - 6'd1);
        end
        case (mode)
          RM_NEAREST_EVEN: inc = (rem > half) || (rem == half && ip[0]);
          RM_DOWN:         inc = neg && (rem != 64'd0);
          RM_UP:           inc = !neg && (rem != 64'd0);
          default:         inc = 1'b0;
        endcase
      end
      mag = ip + {63'd0, inc};
      if (wide) lim = neg ? Ind64 : Max64;
      else      lim = neg ? Ind32 : Max32;
      if (mag > lim) begin
        res = indef;
      end else begin
        if (neg) mag = 64'd0 - mag;
        res = wide ? mag : {32'd0, mag[31:0]};
      end
    end
    return res;
  endfunction

endpackage

FILE: design/d2i_if.sv
// valid/ready channel interfaces for the converter
interface d2i_in_if;
  logic              valid;
  logic              ready;
  d2i_pkg::d2i_in_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface d2i_out_if;
  logic              valid;
  logic              ready;
  d2i_pkg::d2i_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/double_to_int_convert_top.sv
// Converts binary64 values to 32- or 64-bit signed integers under truncation or the
// configured rounding mode. Two register stages (input, result): an item transferred in
// passes through the input register and then the result register before it is offered out,
// and one item is taken every cycle while the output drains.
// NaN, infinity and out-of-range values give the sign bit of the target width alone;
// 32-bit results are zero-extended. An item takes the rounding mode in effect as it enters the result register.
`include "double_to_int_convert_top_defines.svh"
module double_to_int_convert_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  d2i_in_if.sink      in_if,
  d2i_out_if.source   out_if
);

  d2i_pkg::rmode_e mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= d2i_pkg::RM_NEAREST_EVEN;
    end else if (cfg_we_i) begin
      mode_q <= d2i_pkg::rmode_e'(cfg_wdata_i);
    end
  end

  d2i_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mode_i (mode_q),
    .in_if  (in_if),
    .out_if (out_if)
  );

  `D2I_ASSERT(a_ready_when_out_free, (!out_if.valid || out_if.ready) |-> in_if.ready, "input stalled while output free")
  `D2I_ASSERT_NEXT(a_stall_holds, out_if.valid && !out_if.ready, out_if.valid && $stable(out_if.payload.result_bits), "stalled result changed")
  `D2I_ASSERT(a_32bit_upper_zero, (u_core.in_vld_q && !u_core.in_q.result_is_64bit) |-> (u_core.res_d[63:32] == 32'd0), "32-bit result not zero-extended")

endmodule

FILE: design/d2i_core.sv
// conversion datapath: input register, combinational convert, result register
module d2i_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  d2i_pkg::rmode_e     mode_i,
  d2i_in_if.sink              in_if,
  d2i_out_if.source           out_if
);

  logic              in_vld_q;
  d2i_pkg::d2i_in_t  in_q;
  logic              out_vld_q;
  logic [63:0]       res_q;
  logic [63:0]       res_d;
  logic              adv;
  d2i_pkg::rmode_e   mode;

  // the result stage moves whenever it is empty or being drained
  assign adv          = !out_vld_q || out_if.ready;
  assign in_if.ready  = !in_vld_q || adv;
  assign mode         = in_q.operation ? mode_i : d2i_pkg::RM_ZERO;
  assign res_d        = d2i_pkg::convert(in_q.source_bits, mode, in_q.result_is_64bit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_if.ready) in_vld_q <= in_if.valid;
      if (adv) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) in_q <= in_if.payload;
    if (adv && in_vld_q) res_q <= res_d;
  end

  assign out_if.valid               = out_vld_q;
  assign out_if.payload.result_bits = res_q;

endmodule

FILE: tb/tb.sv
// testbench for the binary64 to integer converter: directed and random items, scoreboard check
`timescale 1ns / 1ps
module tb;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_wdata_i;

  d2i_in_if  in_ch ();
  d2i_out_if out_ch ();

  double_to_int_convert_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch.sink),
    .out_if      (out_ch.source)
  );

  localparam int IdleLimit  = 20000;
  localparam int HoldCycles = 32;

  d2i_pkg::rmode_e round_mode;
  logic [63:0]     int_expected_q[$];
  int              mismatch_cnt;
  int              err_cnt;
  int              idle_cycles;
  bit              hold_off;
  bit              stall_on;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // exact integer conversion of a binary64 pattern
  function automatic logic [63:0] to_integer(logic [63:0] bits, d2i_pkg::rmode_e mode,
                                             logic wide);
    logic        neg;
    logic [10:0] ex;
    logic [63:0] mant;
    int          shift;
    int          rshift;
    logic [63:0] whole;
    logic [63:0] frac_part;
    logic [63:0] halfway;
    logic        bump;
    logic [63:0] mag;
    logic [63:0] limit;
    logic [63:0] bad;
    neg  = bits[63];
    ex   = bits[62:52];
    bad  = wide ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
    bump = 1'b0;
    if (ex == 11'h7ff) return bad;
    mant  = {11'd0, ex != 0, bits[51:0]};
    shift = (ex != 0) ? int'(ex) - 1075 : -1074;
    if (shift >= 11) return bad;
    if (shift >= 0) begin
      whole = mant << shift;
    end else begin
      rshift = -shift;
      if (rshift >= 60) begin
        whole     = 64'd0;
        frac_part = {63'd0, mant != 0};
        halfway   = 64'd1 << 58;
      end else begin
        whole     = mant >> rshift;
        frac_part = mant & ((64'd1 << rshift) - 64'd1);
        halfway   = 64'd1 << (rshift - 1);
      end
      case (mode)
        d2i_pkg::RM_NEAREST_EVEN:
          bump = (frac_part > halfway) || (frac_part == halfway && whole[0]);
        d2i_pkg::RM_DOWN: bump = neg && frac_part != 0;
        d2i_pkg::RM_UP:   bump = !neg && frac_part != 0;
        default:          bump = 1'b0;
      endcase
    end
    mag = whole + {63'd0, bump};
    if (wide) limit = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    else      limit = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7fff_ffff;
    if (mag > limit) return bad;
    if (neg) mag = 64'd0 - mag;
    return wide ? mag : {32'd0, mag[31:0]};
  endfunction

  // offers one item and returns at the falling edge after its transfer, valid still high
  task automatic send_value(logic [63:0] bits, logic op, logic wide);
    in_ch.payload <= '{source_bits: bits, operation: op, result_is_64bit: wide};
    in_ch.valid   <= 1'b1;
    int_expected_q.push_back(to_integer(bits, op ? round_mode : d2i_pkg::RM_ZERO, wide));
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_input();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // random gap between bursts, sometimes none
  task automatic maybe_gap();
    if ($urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (int_expected_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_mode(d2i_pkg::rmode_e mode);
    wait_drained();
    cfg_wdata_i <= mode;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    round_mode = mode;
  endtask

  function automatic logic [63:0] rand_double();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v[62:52] = 11'd1023 + 11'($urandom_range(0, 66)) - 11'd2;
      1: v[62:52] = 11'd1023 + 11'($urandom_range(0, 34));
      2: v[62:52] = 11'd1023 - 11'($urandom_range(0, 3));
      3: begin
        v[62:52] = 11'd1075 - 11'($urandom_range(1, 3));
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_directed();
    logic [63:0] vals[20];
    vals = '{64'h0, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001, 64'h800f_ffff_ffff_ffff,
             64'h7ff0_0000_0000_0000, 64'hfff0_0000_0000_0000, 64'h7ff8_0000_0000_0001,
             64'h3fe0_0000_0000_0000, 64'h3ff8_0000_0000_0000, 64'hbff8_0000_0000_0000,
             64'h4004_0000_0000_0000, 64'h41df_ffff_ffc0_0000, 64'hc1e0_0000_0000_0000,
             64'hc1e0_0000_0010_0000, 64'h41e0_0000_0000_0000, 64'hc3e0_0000_0000_0000,
             64'h43e0_0000_0000_0000, 64'h43df_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
             64'hbfe0_0000_0000_0001};
    foreach (vals[k]) send_value(vals[k], k[0], k[1]);
    idle_input();
  endtask

  task automatic test_random(int count);
    for (int k = 0; k < count; k++) begin
      send_value(rand_double(), $urandom_range(0, 1), $urandom_range(0, 1));
      maybe_gap();
    end
    idle_input();
  endtask

  // receiver holds off while the sender keeps offering, payload held until its transfer
  task automatic test_backpressure();
    logic [63:0] bits;
    wait_drained();
    hold_off = 1'b1;
    bits     = rand_double();
    for (int k = 0; k < 48; k++) begin
      in_ch.payload <= '{source_bits: bits, operation: 1'b1, result_is_64bit: 1'b1};
      in_ch.valid   <= 1'b1;
      @(posedge clk_i);
      if (in_ch.ready) begin
        int_expected_q.push_back(to_integer(bits, round_mode, 1'b1));
        bits = rand_double();
      end
      @(negedge clk_i);
    end
    idle_input();
    wait_drained();
  endtask

  // receiver stall pattern, plus a long counted hold-off when asked
  initial begin
    int hold_cnt;
    out_ch.ready = 1'b0;
    stall_on     = 1'b0;
    hold_cnt     = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        hold_off = 1'b0;
        hold_cnt = HoldCycles;
      end
      if ($urandom_range(0, 31) == 0) stall_on = !stall_on;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(stall_on && $urandom_range(0, 1));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (int_expected_q.size() == 0) begin
        err_cnt++;
        if (mismatch_cnt < 10) $display("unexpected result %h", out_ch.payload.result_bits);
        mismatch_cnt++;
      end else begin
        if (out_ch.payload.result_bits !== int_expected_q[0]) begin
          err_cnt++;
          if (mismatch_cnt < 10)
            $display("result mismatch: expected %h actual %h", int_expected_q[0],
                     out_ch.payload.result_bits);
          mismatch_cnt++;
        end
        void'(int_expected_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("double_to_int_convert_top verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 2'd0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    round_mode    = d2i_pkg::RM_NEAREST_EVEN;
    mismatch_cnt  = 0;
    err_cnt       = 0;
    idle_cycles   = 0;
    hold_off      = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    write_mode(d2i_pkg::RM_DOWN);
    test_directed();
    write_mode(d2i_pkg::RM_UP);
    test_directed();
    write_mode(d2i_pkg::RM_ZERO);
    test_directed();
    test_backpressure();
    for (int p = 0; p < 4; p++) begin
      write_mode(d2i_pkg::rmode_e'($urandom_range(0, 3)));
      test_random(340);
    end
    write_mode(d2i_pkg::RM_NEAREST_EVEN);
    test_random(40);
    wait_drained();
    repeat (10) @(negedge clk_i);
    if (err_cnt == 0 && int_expected_q.size() == 0) begin
      $display("double_to_int_convert_top verification clean");
    end else begin
      $display("double_to_int_convert_top verification failed");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+design
design/d2i_pkg.sv
design/d2i_if.sv
design/d2i_core.sv
design/double_to_int_convert_top.sv
tb/tb.sv
